/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions. They compile to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/pal_pkg.sv */
// ---------------------------------------------------------------------------
// pal_pkg
// Constants, codes and types shared by the positional array list engine.
// ---------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Wide enough to compare an 8-bit position against count + 1.
  localparam int CMP_W    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 3;
  localparam int OUT_W    = 8;
  localparam int OP_W     = 3;

  // Command queue depth; must be a power of two so the pointers wrap.
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Request types.
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // Storage operations carried out by the back end.
  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_INS  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 3'd2;
  localparam logic [OP_W-1:0] OP_SRCH = 3'd3;
  localparam logic [OP_W-1:0] OP_WR   = 3'd4;
  localparam logic [OP_W-1:0] OP_RD   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  addr;
    logic [CNT_W-1:0]  cnt_before;
    logic [CNT_W-1:0]  cnt_after;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

/* hdl/pal_ram.sv */
// ---------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pal_front.sv */
// ---------------------------------------------------------------------------
// pal_front
// Accepts requests, checks them against the running entry count and turns
// them into storage commands with their status already settled.
// ---------------------------------------------------------------------------
module pal_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pal_pkg::REQ_W-1:0]  in_req_type,
  input  logic [pal_pkg::POS_W-1:0]  in_position,
  input  logic signed [pal_pkg::DATA_W-1:0] in_value,
  input  pal_pkg::qstat_t            q_stat,
  output logic                       q_push,
  output pal_pkg::cmd_t              q_cmd
);
  import pal_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             pos_zero;
  logic             is_empty;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    pos_x    = CMP_W'(in_position);
    cnt_x    = CMP_W'(cnt_r);
    pos_zero = (in_position == '0);
    is_empty = (cnt_r == '0);
    cnt_nxt  = cnt_r;

    q_cmd.op         = OP_NONE;
    q_cmd.status     = ST_OK;
    q_cmd.addr       = IDX_W'(pos_x - CMP_W'(1));
    q_cmd.cnt_before = cnt_r;
    q_cmd.value      = in_value;

    case (in_req_type)
      REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      REQ_INSERT: begin
        // A full list is reported before the position is looked at.
        if (cnt_r == CNT_W'(CAPACITY)) begin
          q_cmd.status = ST_FULL;
        end else if (pos_zero || pos_x > cnt_x + CMP_W'(1)) begin
          q_cmd.status = ST_BADPOS;
        end else begin
          q_cmd.op = OP_INS;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (is_empty) begin
          q_cmd.status = ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          q_cmd.status = ST_BADPOS;
        end else begin
          q_cmd.op = OP_DEL;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      REQ_SEARCH: begin
        if (is_empty) begin
          q_cmd.status = ST_EMPTY;
        end else begin
          q_cmd.op = OP_SRCH;
        end
      end
      REQ_UPDATE: begin
        if (is_empty) begin
          q_cmd.status = ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          q_cmd.status = ST_BADPOS;
        end else begin
          q_cmd.op = OP_WR;
        end
      end
      REQ_READ: begin
        if (is_empty) begin
          q_cmd.status = ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          q_cmd.status = ST_BADPOS;
        end else begin
          q_cmd.op = OP_RD;
        end
      end
      default: begin
        q_cmd.status = ST_BADPOS;
      end
    endcase

    q_cmd.cnt_after = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/pal_queue.sv */
// ---------------------------------------------------------------------------
// pal_queue
// Short command queue between the request front end and the storage back
// end.
// ---------------------------------------------------------------------------
module pal_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pal_pkg::cmd_t   cmd_in,
  input  logic            pop,
  output pal_pkg::cmd_t   cmd_out,
  output pal_pkg::qstat_t stat
);
  import pal_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] fill_r;
  logic [QCNT_W-1:0] fill_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + QCNT_W'(1);
      2'b01:   fill_nxt = fill_r - QCNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  assign cmd_out        = slot_r[rd_r];
  assign stat.full      = (fill_r == QCNT_W'(QDEPTH));
  assign stat.not_empty = (fill_r != '0);

endmodule

/* hdl/pal_back.sv */
// ---------------------------------------------------------------------------
// pal_back
// Carries out storage commands on the entry RAM: shifts for insert and
// delete, a linear scan for search, single accesses for update and read,
// and holds the result register.
// ---------------------------------------------------------------------------
module pal_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pal_pkg::qstat_t            q_stat,
  input  pal_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pal_pkg::ST_W-1:0]   out_status,
  output logic [pal_pkg::OUT_W-1:0]  out_found_position,
  output logic signed [pal_pkg::DATA_W-1:0] out_read_value,
  output logic [pal_pkg::OUT_W-1:0]  out_element_count
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN  = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_UP   = 3'd4;
  localparam logic [2:0] S_INSW = 3'd5;
  localparam logic [2:0] S_DN   = 3'd6;

  logic [2:0]        st_r;
  logic [2:0]        st_nxt;
  cmd_t              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [IDX_W-1:0]  last_idx;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  logic              fin;
  logic [ST_W-1:0]   fin_status;
  logic [CNT_W-1:0]  fin_found;
  logic [DATA_W-1:0] fin_rd;

  logic              out_valid_r;
  logic [ST_W-1:0]   status_r;
  logic [OUT_W-1:0]  found_r;
  logic [DATA_W-1:0] rd_r;
  logic [OUT_W-1:0]  count_r;

  pal_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // In the scan states, idx_r is the entry whose read data arrives this cycle.
  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = cmd_r.addr;
    wdata      = cmd_r.value;
    raddr      = idx_r;
    fin        = 1'b0;
    fin_status = cmd_r.status;
    fin_found  = '0;
    fin_rd     = '0;
    last_idx   = IDX_W'(cmd_r.cnt_before - CNT_W'(1));

    case (st_r)
      S_IDLE: begin
        if (q_stat.not_empty && !out_valid_r) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_WR: begin
              we     = 1'b1;
              waddr  = q_cmd.addr;
              wdata  = q_cmd.value;
              st_nxt = S_FIN;
            end
            OP_RD: begin
              raddr  = q_cmd.addr;
              st_nxt = S_RDW;
            end
            OP_SRCH: begin
              raddr   = '0;
              idx_nxt = '0;
              st_nxt  = S_SRCH;
            end
            OP_INS: begin
              if (CNT_W'(q_cmd.addr) == q_cmd.cnt_before) begin
                // Appending needs no shift.
                we     = 1'b1;
                waddr  = q_cmd.addr;
                wdata  = q_cmd.value;
                st_nxt = S_FIN;
              end else begin
                raddr   = IDX_W'(q_cmd.cnt_before - CNT_W'(1));
                idx_nxt = IDX_W'(q_cmd.cnt_before - CNT_W'(1));
                st_nxt  = S_UP;
              end
            end
            OP_DEL: begin
              if (CNT_W'(q_cmd.addr) == q_cmd.cnt_before - CNT_W'(1)) begin
                // Dropping the last entry needs no shift.
                st_nxt = S_FIN;
              end else begin
                raddr   = q_cmd.addr + IDX_W'(1);
                idx_nxt = q_cmd.addr + IDX_W'(1);
                st_nxt  = S_DN;
              end
            end
            default: begin
              st_nxt = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        fin    = 1'b1;
        st_nxt = S_IDLE;
      end
      S_RDW: begin
        fin    = 1'b1;
        fin_rd = rdata;
        st_nxt = S_IDLE;
      end
      S_SRCH: begin
        if (rdata == cmd_r.value) begin
          fin        = 1'b1;
          fin_status = ST_OK;
          fin_found  = CNT_W'(idx_r) + CNT_W'(1);
          st_nxt     = S_IDLE;
        end else if (idx_r == last_idx) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          st_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          raddr   = idx_r + IDX_W'(1);
        end
      end
      S_UP: begin
        // Move one entry up while the one below it is being read.
        we    = 1'b1;
        waddr = idx_r + IDX_W'(1);
        wdata = rdata;
        if (idx_r == cmd_r.addr) begin
          st_nxt = S_INSW;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
          raddr   = idx_r - IDX_W'(1);
        end
      end
      S_INSW: begin
        we     = 1'b1;
        fin    = 1'b1;
        st_nxt = S_IDLE;
      end
      S_DN: begin
        we    = 1'b1;
        waddr = idx_r - IDX_W'(1);
        wdata = rdata;
        if (idx_r == last_idx) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          raddr   = idx_r + IDX_W'(1);
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (fin) begin
      status_r <= fin_status;
      found_r  <= OUT_W'(fin_found);
      rd_r     <= fin_rd;
      count_r  <= OUT_W'(cmd_r.cnt_after);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_read_value     = rd_r;
  assign out_element_count  = count_r;

endmodule

/* hdl/positional_array_list_engine_unit.sv */
// ---------------------------------------------------------------------------
// positional_array_list_engine_unit
// Ordered list of signed 32-bit entries with clear, insert, delete, search,
// update and read requests; one result with status and count per request.
// ---------------------------------------------------------------------------
// The front end checks each request against the entry count in the cycle it
// is accepted and queues it; up to two requests wait in the queue while the
// back end works on the entry RAM (one write and one registered read port).
// Search scans from the first entry up to the first match or to the last
// entry, insert in the middle shifts the entries from the position upward
// and delete shifts the entries above the position down (no shift for an
// appending insert or for deleting the last entry); update and read are
// single RAM accesses. A new request starts once the previous result has
// left the output register. No clearing pass is needed after reset: only
// entries below the count are ever read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_array_list_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pal_pkg::REQ_W-1:0]  in_req_type,
  input  logic [pal_pkg::POS_W-1:0]  in_position,
  input  logic signed [pal_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pal_pkg::ST_W-1:0]   out_status,
  output logic [pal_pkg::OUT_W-1:0]  out_found_position,
  output logic signed [pal_pkg::DATA_W-1:0] out_read_value,
  output logic [pal_pkg::OUT_W-1:0]  out_element_count
);
  import pal_pkg::*;

  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  cmd_t   push_cmd;
  cmd_t   head_cmd;

  pal_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_value   (in_value),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  pal_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (push_cmd),
    .pop    (q_pop),
    .cmd_out(head_cmd),
    .stat   (q_stat)
  );

  pal_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  // The back end only takes a command that exists, and only with a free output.
  `ASSERT_IMPLY(a_pop_ready, clk, rst_n, q_pop, q_stat.not_empty && !out_valid, "pop without command or with busy output")
  // A full status can only come from a list that holds CAPACITY entries.
  `ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_element_count == OUT_W'(CAPACITY), "full status with wrong count")
  // A found position is reported only with an ok status.
  `ASSERT_IMPLY(a_found_ok, clk, rst_n, out_valid && (out_found_position != '0), out_status == ST_OK, "found position without ok status")
  // Nothing is pushed into a full queue unless a command is popped in the same cycle.
  `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(q_push && q_stat.full && !q_pop), "push into full queue")

endmodule
